// ===== src/ltc_pkg.sv =====
// ----------------------------------------------------------------------------
// ltc_pkg: shared types and constants of the LRU tag cache
// Item formats on both channels, and the search and update records that
// run along the chain of entry cells.
// ----------------------------------------------------------------------------
package ltc_pkg;

    // Default number of entries, and the index width of the chain records (enough for 256 entries)
    localparam int unsigned DEFAULT_ENTRIES = 16;
    localparam int unsigned IDX_W           = 8;
    localparam int unsigned KEY_W           = 64;
    localparam int unsigned STAMP_W         = 32;
    localparam int unsigned OUT_IDX_W       = 4;

    // Opcodes
    localparam logic OP_LOOKUP     = 1'b0;
    localparam logic OP_INVALIDATE = 1'b1;

    // Input item
    typedef struct packed {
        logic               opcode;
        logic [KEY_W-1:0]   lookup_key;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic                   hit;
        logic [OUT_IDX_W-1:0]   entry_index;
        logic                   evicted_valid;
        logic [KEY_W-1:0]       evicted_key;
    } t_out_item;

    // Search record handed from cell to cell
    typedef struct packed {
        logic                 valid;
        logic [KEY_W-1:0]     key;
        logic                 hit;
        logic [IDX_W-1:0]     hit_idx;
        logic [STAMP_W-1:0]   min_stamp;
        logic [IDX_W-1:0]     cand;
        logic                 cand_valid;
        logic [KEY_W-1:0]     cand_key;
    } t_pkt;

    // Update broadcast from the controller to every cell
    typedef struct packed {
        logic                 clear;
        logic                 en;
        logic                 install;
        logic [IDX_W-1:0]     idx;
        logic [KEY_W-1:0]     key;
        logic [STAMP_W-1:0]   stamp;
    } t_upd;

endpackage

// ===== src/lru_tick_tag_cache.sv =====
// ----------------------------------------------------------------------------
// lru_tick_tag_cache: fully associative tag store with LRU replacement
// A lookup walks a search record down a chain of ENTRIES cells, one cell
// per cycle, then writes the hit entry's stamp or installs the key in the
// victim entry. One item is in work at a time.
// ----------------------------------------------------------------------------
// A lookup launches its search record into the chain at the accepting edge;
// the record then passes through the register of every entry cell in turn.
// When it leaves the last cell the entry is written back and the result is
// held, and the result then loads the output register once that is free.
// An invalidate clears every entry at its accepting edge and then offers an
// all-zero result. The next item is accepted as soon as the previous one has
// reached the output register, even if that result is still stalled. No
// clearing pass after reset: valid bits reset at once.
module lru_tick_tag_cache
    import ltc_pkg::*;
#(
    parameter int unsigned ENTRIES = DEFAULT_ENTRIES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [STAMP_W-1:0] r_tick;
    t_pkt               r_launch;
    t_out_item          r_res;
    t_out_item          r_out;
    logic               r_out_valid;
    t_out_item          n_res;
    t_upd               w_upd;
    logic               w_accept;
    t_pkt               w_pkt [ENTRIES+1];
    logic [ENTRIES:0]   w_live;
    t_pkt               w_tail;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Launch the search record into the first cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_launch <= '0;
        end else begin
            r_launch.valid      <= w_accept && (i_in_data.opcode == OP_LOOKUP);
            r_launch.key        <= i_in_data.lookup_key;
            r_launch.hit        <= 1'b0;
            r_launch.hit_idx    <= '0;
            r_launch.min_stamp  <= '1;
            r_launch.cand       <= '0;
            r_launch.cand_valid <= 1'b0;
            r_launch.cand_key   <= '0;
        end
    end

    // Chain of entry cells
    assign w_pkt[0] = r_launch;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        ltc_cell #(
            .CELL_IDX(IDX_W'(g))
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_pkt  (w_pkt[g]),
            .i_upd  (w_upd),
            .o_pkt  (w_pkt[g+1])
        );
    end

    for (genvar g = 0; g <= ENTRIES; g++) begin : g_live
        assign w_live[g] = w_pkt[g].valid;
    end

    assign w_tail = w_pkt[ENTRIES];

    // Write back: touch the hit entry or install into the victim
    always_comb begin
        w_upd.clear   = w_accept && (i_in_data.opcode == OP_INVALIDATE);
        w_upd.en      = w_tail.valid;
        w_upd.install = !w_tail.hit;
        w_upd.idx     = w_tail.hit ? w_tail.hit_idx : w_tail.cand;
        w_upd.key     = w_tail.key;
        w_upd.stamp   = r_tick;
    end

    // Form the result from the search record at the chain's end
    always_comb begin
        n_res = '0;
        if (w_tail.hit) begin
            n_res.hit         = 1'b1;
            n_res.entry_index = OUT_IDX_W'(w_tail.hit_idx);
        end else begin
            n_res.entry_index   = OUT_IDX_W'(w_tail.cand);
            n_res.evicted_valid = w_tail.cand_valid;
            n_res.evicted_key   = w_tail.cand_valid ? w_tail.cand_key : '0;
        end
    end

    // Sequence the item; hold the use counter and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the taken result unless a new one loads in this cycle
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_in_data.opcode == OP_INVALIDATE) begin
                            r_tick  <= '0;
                            r_res   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_tick  <= r_tick + 1'b1;
                            r_state <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH: begin
                    if (w_tail.valid) begin
                        r_res   <= n_res;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // At most one search record in the chain
    a_one_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_live) <= 1)
        else $error("more than one search record in flight");

    // The chain only delivers while the controller waits for it
    a_tail_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail.valid |-> (r_state == S_SEARCH))
        else $error("search record arrived outside the search state");

    // Invalidate restarts the use counter
    a_inval_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in_data.opcode == OP_INVALIDATE)) |=> (r_tick == '0))
        else $error("use counter not cleared by invalidate");

    // A hit never reports an eviction
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.hit) |-> !r_out.evicted_valid)
        else $error("hit result reports an eviction");

endmodule

// ===== src/ltc_cell.sv =====
// ----------------------------------------------------------------------------
// ltc_cell: one entry of the LRU tag cache
// Holds valid, key and use stamp of one entry. Folds its entry into the
// passing search record (first hit, running minimum stamp) and registers
// the record for the next cell. Applies broadcast updates to itself.
// ----------------------------------------------------------------------------
module ltc_cell
    import ltc_pkg::*;
#(
    parameter logic [IDX_W-1:0] CELL_IDX = '0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_pkt i_pkt,
    input  t_upd i_upd,
    output t_pkt o_pkt
);

    logic               r_valid;
    logic [KEY_W-1:0]   r_key;
    logic [STAMP_W-1:0] r_stamp;
    t_pkt               r_pkt;
    t_pkt               n_pkt;
    logic               w_match;
    logic               w_take;

    // Compare this entry against the passing search record
    assign w_match = r_valid && (r_key == i_pkt.key);
    // The first cell takes the candidate slot unless its entry matches: it is the default victim
    assign w_take  = !r_valid || (r_stamp < i_pkt.min_stamp) || (CELL_IDX == '0);

    always_comb begin
        n_pkt = i_pkt;
        if (!i_pkt.hit) begin
            if (w_match) begin
                n_pkt.hit     = 1'b1;
                n_pkt.hit_idx = CELL_IDX;
            end else if (w_take) begin
                n_pkt.min_stamp  = r_valid ? r_stamp : '0;
                n_pkt.cand       = CELL_IDX;
                n_pkt.cand_valid = r_valid;
                n_pkt.cand_key   = r_key;
            end
        end
    end

    // Hold entry valid bit; clear on invalidate, set on install
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_upd.clear) begin
            r_valid <= 1'b0;
        end else if (i_upd.en && i_upd.install && (i_upd.idx == CELL_IDX)) begin
            r_valid <= 1'b1;
        end
    end

    // Write the stamp of the addressed entry, and its key on install
    always_ff @(posedge i_clk) begin
        if (i_upd.en && (i_upd.idx == CELL_IDX)) begin
            r_stamp <= i_upd.stamp;
            if (i_upd.install) begin
                r_key <= i_upd.key;
            end
        end
    end

    // Advance the search record to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt <= '0;
        end else begin
            r_pkt <= n_pkt;
        end
    end

    assign o_pkt = r_pkt;

endmodule
